### sv/sync_block_frame_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync block frame parser
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_BLOCK_FRAME_PARSER_CORE_MACROS_SVH
`define SYNC_BLOCK_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBFP_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("sbfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBFP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("sbfp: next-cycle check failed");

`endif

### sv/sbfp_pkg.sv
// ----------------------------------------------------------------------------
// Sync block frame parser package
// Shared types, register codes and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbfp_pkg;

    localparam int WORD_W      = 16;
    localparam int BLOCK_WORDS = 7;
    localparam int OBJ_W       = 6 * WORD_W;
    localparam int SUM_W       = 19;
    localparam int OCNT_W      = 5;
    localparam int OUT_DATA_W  = 104;
    localparam int OUT_USER_W  = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_LIMIT = 2'd2;

    localparam logic [15:0] RST_SYNC_WORD   = 16'haa55;
    localparam logic [7:0]  RST_IDLE_LIMIT  = 8'd16;
    localparam logic [7:0]  RST_EMPTY_LIMIT = 8'd5;
    localparam logic [7:0]  COUNT_SAT       = 8'hff;

    localparam logic OP_BEGIN = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_state;

    typedef struct packed {
        logic begin_col;
        logic idle_inc;
        logic start_save;
        logic clear_frame;
        logic keep;
        logic blk_restart;
        logic append;
        logic set_prev;
        logic clr_prev;
        logic clr_first;
        logic finish;
        logic timeout;
        logic rd_en;
        logic rd_next;
    } t_cmd;

    typedef struct packed {
        logic collecting;
        logic saving;
        logic prev_sync;
        logic first_sync;
        logic is_zero;
        logic is_sync;
        logic idle_hit;
        logic last_result;
    } t_stat;

endpackage

### sv/sync_block_frame_parser_core.sv
// ----------------------------------------------------------------------------
// Sync block frame parser.
// Input channel s_axis: tuser is the operation (0 begins a collection, 1 carries
// a word), tdata is the received 16-bit word. Output channel m_axis carries one
// item per kept object, or a single item without an object, with tlast on the
// final item of the run. Registers are written through i_cfg_we, i_cfg_index
// and i_cfg_data, only while the block is idle: a user rule, not enforced.
// Input words stream at one per cycle while no result run is in progress.
// An item that ends a collection starts the result run instead: for each result
// item the object store is read into a register in ST_READ and the item is shown
// from the next cycle on in ST_SHOW; the next read starts only once the shown
// item is taken. No input item is taken during a run.
// When the receiver stalls, the shown item holds until it is taken.
// Synchronous reset clears the parser state and loads the register defaults;
// the object store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_block_frame_parser_core
    import sbfp_pkg::*;
#(
    parameter int MAX_OBJECTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // word
    input  logic                  s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // checksum, signature, x_pos, y_pos, width, height, object_count, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // has_object, frame_empty, timed_out, overflow
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    sbfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sbfp_dp #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

### sv/sbfp_ctrl.sv
// ----------------------------------------------------------------------------
// Sync block frame parser controller
// Decodes accepted items into datapath commands and sequences the result run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfp_ctrl
    import sbfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    if (i_in_op == OP_BEGIN) begin
                        o_cmd.begin_col = 1'b1;
                    end else if (i_stat.collecting) begin
                        if (i_stat.saving) begin
                            if (i_stat.is_zero) begin
                                o_cmd.keep        = 1'b1;
                                o_cmd.blk_restart = 1'b1;
                                o_cmd.finish      = 1'b1;
                                n_state           = ST_READ;
                            end else if (i_stat.is_sync) begin
                                if (!i_stat.prev_sync) begin
                                    o_cmd.set_prev = 1'b1;
                                    if (!i_stat.first_sync) begin
                                        o_cmd.keep = 1'b1;
                                    end else begin
                                        o_cmd.clr_first = 1'b1;
                                    end
                                end else begin
                                    o_cmd.clear_frame = 1'b1;
                                end
                                o_cmd.blk_restart = 1'b1;
                                o_cmd.append      = 1'b1;
                            end else begin
                                o_cmd.clr_prev = 1'b1;
                                o_cmd.append   = 1'b1;
                            end
                        end else if (i_stat.is_sync) begin
                            o_cmd.start_save = 1'b1;
                        end else begin
                            o_cmd.idle_inc = 1'b1;
                            if (i_stat.idle_hit) begin
                                o_cmd.finish  = 1'b1;
                                o_cmd.timeout = 1'b1;
                                n_state       = ST_READ;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_SHOW;
            end
            ST_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last_result) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/sbfp_dp.sv
// ----------------------------------------------------------------------------
// Sync block frame parser datapath
// Configuration, block assembly with running checksum, object store and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfp_dp
    import sbfp_pkg::*;
#(
    parameter int MAX_OBJECTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data,
    input  logic [WORD_W-1:0]     i_word,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic [OUT_USER_W-1:0] o_out_user,
    output logic                  o_out_last
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);

    logic [WORD_W-1:0] r_sync_word;
    logic [7:0]        r_idle_limit;
    logic [7:0]        r_empty_limit;

    logic              r_collecting;
    logic              r_saving;
    logic              r_first;
    logic              r_prev;
    logic [7:0]        r_idle_count;
    logic [2:0]        r_blk_len;
    logic [SUM_W-1:0]  r_sum;
    logic [CW-1:0]     r_frame_count;
    logic              r_dropped;
    logic [7:0]        r_empty_run;
    logic              r_timed_out;
    logic [AW-1:0]     r_k;

    logic [WORD_W-1:0] r_blk [1:BLOCK_WORDS-1];
    logic [OBJ_W-1:0]  r_mem [0:MAX_OBJECTS-1];
    logic [OBJ_W-1:0]  r_rd_data;

    logic [7:0]        idle_next;
    logic              blk_good;
    logic              store_full;
    logic              do_store;
    logic              has_object;
    logic              frame_empty;
    logic [OBJ_W-1:0]  obj_data;

    assign idle_next  = (r_idle_count == COUNT_SAT) ? r_idle_count : r_idle_count + 8'd1;
    assign blk_good   = (r_blk_len == 3'(BLOCK_WORDS)) &&
                        ({{(SUM_W-WORD_W){1'b0}}, r_blk[1]} == r_sum);
    assign store_full = (r_frame_count >= CW'(MAX_OBJECTS));
    assign do_store   = i_cmd.keep && blk_good && !store_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word   <= RST_SYNC_WORD;
            r_idle_limit  <= RST_IDLE_LIMIT;
            r_empty_limit <= RST_EMPTY_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_WORD:   r_sync_word   <= i_cfg_data;
                CFG_IDLE_LIMIT:  r_idle_limit  <= i_cfg_data[7:0];
                CFG_EMPTY_LIMIT: r_empty_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting  <= 1'b0;
            r_saving      <= 1'b0;
            r_first       <= 1'b0;
            r_prev        <= 1'b0;
            r_idle_count  <= '0;
            r_blk_len     <= '0;
            r_sum         <= '0;
            r_frame_count <= '0;
            r_dropped     <= 1'b0;
            r_empty_run   <= '0;
            r_timed_out   <= 1'b0;
            r_k           <= '0;
        end else begin
            if (i_cmd.begin_col) begin
                r_collecting  <= 1'b1;
                r_saving      <= 1'b0;
                r_first       <= 1'b0;
                r_prev        <= 1'b0;
                r_idle_count  <= '0;
                r_blk_len     <= '0;
                r_sum         <= '0;
                r_frame_count <= '0;
                r_dropped     <= 1'b0;
            end
            if (i_cmd.idle_inc) begin
                r_idle_count <= idle_next;
            end
            if (i_cmd.start_save) begin
                r_saving      <= 1'b1;
                r_first       <= 1'b1;
                r_frame_count <= '0;
                r_dropped     <= 1'b0;
            end
            if (i_cmd.clear_frame) begin
                r_frame_count <= '0;
                r_dropped     <= 1'b0;
            end
            if (i_cmd.keep && blk_good) begin
                if (store_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_frame_count <= r_frame_count + CW'(1);
                end
            end
            if (i_cmd.set_prev) begin
                r_prev <= 1'b1;
            end
            if (i_cmd.clr_prev) begin
                r_prev <= 1'b0;
            end
            if (i_cmd.clr_first) begin
                r_first <= 1'b0;
            end
            if (i_cmd.blk_restart) begin
                r_blk_len <= i_cmd.append ? 3'd1 : 3'd0;
                r_sum     <= '0;
            end else if (i_cmd.append && (r_blk_len < 3'(BLOCK_WORDS))) begin
                r_blk_len <= r_blk_len + 3'd1;
                if (r_blk_len >= 3'd2) begin
                    r_sum <= r_sum + {{(SUM_W-WORD_W){1'b0}}, i_word};
                end
            end
            if (i_cmd.finish) begin
                r_collecting <= 1'b0;
                r_saving     <= 1'b0;
                r_timed_out  <= i_cmd.timeout;
                r_k          <= '0;
                if (i_cmd.timeout) begin
                    if (r_empty_run != COUNT_SAT) begin
                        r_empty_run <= r_empty_run + 8'd1;
                    end
                end else begin
                    r_empty_run <= '0;
                end
            end
            if (i_cmd.rd_next) begin
                r_k <= r_k + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !i_cmd.blk_restart && (r_blk_len != 3'd0) &&
            (r_blk_len < 3'(BLOCK_WORDS))) begin
            r_blk[r_blk_len] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[r_frame_count[AW-1:0]] <= {r_blk[6], r_blk[5], r_blk[4],
                                             r_blk[3], r_blk[2], r_blk[1]};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    assign has_object  = (r_frame_count != '0);
    assign frame_empty = (r_empty_run >= r_empty_limit);
    assign obj_data    = has_object ? r_rd_data : '0;

    assign o_out_data = {{(OUT_DATA_W-OBJ_W-OCNT_W){1'b0}}, OCNT_W'(r_frame_count), obj_data};
    assign o_out_user = {r_dropped, r_timed_out, frame_empty, has_object};
    assign o_out_last = !has_object || (CW'(r_k) == r_frame_count - CW'(1));

    assign o_stat.collecting  = r_collecting;
    assign o_stat.saving      = r_saving;
    assign o_stat.prev_sync   = r_prev;
    assign o_stat.first_sync  = r_first;
    assign o_stat.is_zero     = (i_word == '0);
    assign o_stat.is_sync     = (i_word == r_sync_word);
    assign o_stat.idle_hit    = (idle_next >= r_idle_limit);
    assign o_stat.last_result = o_out_last;

endmodule

### sv/sbfp_checker.sv
// ----------------------------------------------------------------------------
// Sync block frame parser port checker
// Port-level checks on the result channel and input ready, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_block_frame_parser_core_macros.svh"

module sbfp_checker
    import sbfp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    logic empty_shown;

    assign empty_shown = m_axis_tvalid && !m_axis_tuser[0];

    `SBFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SBFP_ASSERT_IMPLY(a_no_input_in_run, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SBFP_ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n, empty_shown, m_axis_tlast)
    `SBFP_ASSERT_IMPLY(a_empty_is_zero, i_clk, i_rst_n, empty_shown, m_axis_tdata == '0)

endmodule

bind sync_block_frame_parser_core sbfp_checker u_sbfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
